// ----- rtl/dph_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dph_pkg
// Types, constants and the sequencer program of the dual-channel PID block.
// ----------------------------------------------------------------------------
package dph_pkg;

    // Fixed field widths
    localparam int HEAD_W   = 16;
    localparam int OUT_W    = 24;
    localparam int GAIN_W   = 16;
    localparam int PERIOD_W = 12;
    localparam int RATE_W   = 10;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int FRAC_W   = 12;

    // Shared multiplier: 16-bit unsigned gain times a 24-bit chunk of a 48-bit operand
    localparam int CHUNK_W  = 24;
    localparam int OPB_W    = 2 * CHUNK_W;
    localparam int MUL_W    = GAIN_W + 1 + CHUNK_W + 1;
    localparam int ACC_W    = 64;
    localparam int SUM_W    = ACC_W - FRAC_W + 2;

    // Program counter
    localparam int PC_W     = 5;
    localparam logic [PC_W-1:0] PC_IDLE = '0;

    // pi and 2*pi in Q3.12
    localparam logic signed [HEAD_W+1:0] PI_Q12     = 18'sd12868;
    localparam logic signed [HEAD_W+1:0] TWO_PI_Q12 = 18'sd25736;

    // Register reset values
    localparam logic [GAIN_W-1:0]   RST_RANGE_KP   = 16'd2048;
    localparam logic [GAIN_W-1:0]   RST_RANGE_KI   = 16'd41;
    localparam logic [GAIN_W-1:0]   RST_RANGE_KD   = 16'd410;
    localparam logic [GAIN_W-1:0]   RST_HEADING_KP = 16'd4096;
    localparam logic [GAIN_W-1:0]   RST_HEADING_KI = 16'd205;
    localparam logic [GAIN_W-1:0]   RST_HEADING_KD = 16'd41;
    localparam logic [PERIOD_W-1:0] RST_PERIOD     = 12'd410;
    localparam logic [RATE_W-1:0]   RST_RATE       = 10'd10;

    typedef enum logic [2:0] {
        REG_RANGE_KP   = 3'd0,
        REG_RANGE_KI   = 3'd1,
        REG_RANGE_KD   = 3'd2,
        REG_HEADING_KP = 3'd3,
        REG_HEADING_KI = 3'd4,
        REG_HEADING_KD = 3'd5,
        REG_PERIOD     = 3'd6,
        REG_RATE       = 3'd7
    } reg_idx_t;

    // Microcode fields
    typedef enum logic [1:0] {SEQ_NEXT, SEQ_WAIT_IN, SEQ_DONE} seq_t;
    typedef enum logic [2:0] {A_KP, A_KI, A_KD, A_PER, A_RATE} asel_t;
    typedef enum logic [1:0] {B_ERR, B_DIFF, B_INT, B_DER} bsel_t;
    typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADDHI} acc_t;
    typedef enum logic [2:0] {
        WB_NONE, WB_INT_R, WB_INT_H, WB_DER, WB_SUM_LD, WB_SUM_ADD, WB_OUT_R
    } wb_t;

    localparam logic CH_R = 1'b0;
    localparam logic CH_H = 1'b1;
    localparam logic LO   = 1'b0;
    localparam logic HI   = 1'b1;

    typedef struct packed {
        seq_t  seq;
        logic  mul_en;
        logic  ch;
        asel_t asel;
        bsel_t bsel;
        logic  hi;
        acc_t  acc;
        wb_t   wb;
    } uword_t;

    function automatic uword_t uw_make(seq_t s, logic m, logic c, asel_t a, bsel_t b,
                                       logic h, acc_t ac, wb_t w);
        return '{s, m, c, a, b, h, ac, w};
    endfunction

    // Each product: low chunk, high chunk; acc load/add one word later; writeback
    // three words after the low chunk.
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        begin
            case (pc)
                5'd0:  w = uw_make(SEQ_WAIT_IN, 1'b0, CH_R, A_KP,   B_ERR,  LO, ACC_NONE,  WB_NONE);
                // range channel
                5'd1:  w = uw_make(SEQ_NEXT, 1'b1, CH_R, A_PER,  B_ERR,  LO, ACC_NONE,  WB_NONE);
                5'd2:  w = uw_make(SEQ_NEXT, 1'b1, CH_R, A_PER,  B_ERR,  HI, ACC_LOAD,  WB_NONE);
                5'd3:  w = uw_make(SEQ_NEXT, 1'b1, CH_R, A_RATE, B_DIFF, LO, ACC_ADDHI, WB_NONE);
                5'd4:  w = uw_make(SEQ_NEXT, 1'b1, CH_R, A_RATE, B_DIFF, HI, ACC_LOAD,  WB_INT_R);
                5'd5:  w = uw_make(SEQ_NEXT, 1'b1, CH_R, A_KP,   B_ERR,  LO, ACC_ADDHI, WB_NONE);
                5'd6:  w = uw_make(SEQ_NEXT, 1'b1, CH_R, A_KP,   B_ERR,  HI, ACC_LOAD,  WB_DER);
                5'd7:  w = uw_make(SEQ_NEXT, 1'b1, CH_R, A_KI,   B_INT,  LO, ACC_ADDHI, WB_NONE);
                5'd8:  w = uw_make(SEQ_NEXT, 1'b1, CH_R, A_KI,   B_INT,  HI, ACC_LOAD,  WB_SUM_LD);
                5'd9:  w = uw_make(SEQ_NEXT, 1'b1, CH_R, A_KD,   B_DER,  LO, ACC_ADDHI, WB_NONE);
                5'd10: w = uw_make(SEQ_NEXT, 1'b1, CH_R, A_KD,   B_DER,  HI, ACC_LOAD,  WB_SUM_ADD);
                // heading channel
                5'd11: w = uw_make(SEQ_NEXT, 1'b1, CH_H, A_PER,  B_ERR,  LO, ACC_ADDHI, WB_NONE);
                5'd12: w = uw_make(SEQ_NEXT, 1'b1, CH_H, A_PER,  B_ERR,  HI, ACC_LOAD,  WB_SUM_ADD);
                5'd13: w = uw_make(SEQ_NEXT, 1'b1, CH_H, A_RATE, B_DIFF, LO, ACC_ADDHI, WB_OUT_R);
                5'd14: w = uw_make(SEQ_NEXT, 1'b1, CH_H, A_RATE, B_DIFF, HI, ACC_LOAD,  WB_INT_H);
                5'd15: w = uw_make(SEQ_NEXT, 1'b1, CH_H, A_KP,   B_ERR,  LO, ACC_ADDHI, WB_NONE);
                5'd16: w = uw_make(SEQ_NEXT, 1'b1, CH_H, A_KP,   B_ERR,  HI, ACC_LOAD,  WB_DER);
                5'd17: w = uw_make(SEQ_NEXT, 1'b1, CH_H, A_KI,   B_INT,  LO, ACC_ADDHI, WB_NONE);
                5'd18: w = uw_make(SEQ_NEXT, 1'b1, CH_H, A_KI,   B_INT,  HI, ACC_LOAD,  WB_SUM_LD);
                5'd19: w = uw_make(SEQ_NEXT, 1'b1, CH_H, A_KD,   B_DER,  LO, ACC_ADDHI, WB_NONE);
                5'd20: w = uw_make(SEQ_NEXT, 1'b1, CH_H, A_KD,   B_DER,  HI, ACC_LOAD,  WB_SUM_ADD);
                5'd21: w = uw_make(SEQ_NEXT, 1'b0, CH_H, A_KD,   B_DER,  LO, ACC_ADDHI, WB_NONE);
                5'd22: w = uw_make(SEQ_NEXT, 1'b0, CH_H, A_KD,   B_DER,  LO, ACC_NONE,  WB_SUM_ADD);
                5'd23: w = uw_make(SEQ_DONE, 1'b0, CH_H, A_KD,   B_DER,  LO, ACC_NONE,  WB_NONE);
                default: w = uw_make(SEQ_DONE, 1'b0, CH_H, A_KD, B_DER,  LO, ACC_NONE,  WB_NONE);
            endcase
            return w;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/dual_pid_range_heading.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dual_pid_range_heading
// Two-channel discrete PID controller: range -> forward velocity,
// heading -> turn rate.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) takes one control tick per item: range error and raw
//   heading error. The heading is wrapped into [-pi, pi) on capture.
//   Master stream (m_*) returns one item per tick: forward velocity and turn
//   rate (saturated Q11.12) in m_tdata, the clip flag in m_tuser.
//   APB port writes/reads the eight gain and timing registers; write only
//   while the block is idle.
// Sequencing:
//   After the accept cycle an item runs through the whole sequencer program;
//   the next item is accepted only once it is done. The pace comes from ten
//   products run through one shared 17x25 multiplier, two passes each (low
//   and high operand chunk), issued every cycle by the microcode table.
// Reset: gains and timing return to their defaults, integrators and previous
//   errors clear, the output register empties.
// Back-pressure: the finished item sits in the output register; the block
//   accepts and computes the next item meanwhile and holds in its last step
//   until the output register frees up.
// ----------------------------------------------------------------------------
module dual_pid_range_heading #(
    parameter int ERROR_WIDTH      = 24,
    parameter int INTEGRATOR_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    // slave stream: [ERROR_WIDTH-1:0] range_error, next 16 bits heading_raw
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire logic [((ERROR_WIDTH + dph_pkg::HEAD_W + 7) / 8) * 8 - 1:0] s_tdata,
    // master stream: [23:0] forward_velocity, [47:24] turn_rate
    output logic      m_tvalid,
    input  wire logic m_tready,
    output logic [2 * dph_pkg::OUT_W - 1:0] m_tdata,
    // [0] saturated
    output logic [0:0] m_tuser,
    // config port
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [dph_pkg::APB_AW-1:0] paddr,
    input  wire logic [dph_pkg::APB_DW-1:0] pwdata,
    output logic [dph_pkg::APB_DW-1:0] prdata,
    output logic      pready
);

    localparam int EW     = ERROR_WIDTH;
    localparam int IW     = INTEGRATOR_WIDTH;
    localparam int HW     = dph_pkg::HEAD_W;
    localparam int OW     = dph_pkg::OUT_W;
    localparam int GW     = dph_pkg::GAIN_W;
    localparam int CW     = dph_pkg::CHUNK_W;
    localparam int OPB_W  = dph_pkg::OPB_W;
    localparam int MUL_W  = dph_pkg::MUL_W;
    localparam int ACC_W  = dph_pkg::ACC_W;
    localparam int SUM_W  = dph_pkg::SUM_W;
    localparam int FW     = dph_pkg::FRAC_W;
    localparam int PC_W   = dph_pkg::PC_W;
    localparam int DER_W  = EW + 1 + dph_pkg::RATE_W;
    localparam int FL_W   = ACC_W - FW;

    localparam logic signed [SUM_W-1:0] I_MAX = signed'(SUM_W'({1'b0, {(IW-1){1'b1}}}));
    localparam logic signed [SUM_W-1:0] I_MIN = -I_MAX - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] O_MAX = signed'(SUM_W'({1'b0, {(OW-1){1'b1}}}));
    localparam logic signed [SUM_W-1:0] O_MIN = -O_MAX - SUM_W'(1);

    // configuration
    logic [GW-1:0]                    range_kp_reg, range_ki_reg, range_kd_reg;
    logic [GW-1:0]                    heading_kp_reg, heading_ki_reg, heading_kd_reg;
    logic [dph_pkg::PERIOD_W-1:0]     period_reg;
    logic [dph_pkg::RATE_W-1:0]       rate_reg;

    // controller state
    logic signed [IW-1:0]  ri_reg, hi_reg;
    logic signed [EW-1:0]  rp_reg;
    logic signed [HW-1:0]  hp_reg;

    // sequencer and output
    logic [PC_W-1:0]       pc_reg, pc_next;
    logic                  m_tvalid_reg;
    logic [2*OW-1:0]       m_tdata_reg;
    logic                  m_tuser_reg;

    // datapath
    logic signed [EW-1:0]    re_reg;
    logic signed [HW-1:0]    he_reg;
    logic signed [MUL_W-1:0] mul_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [DER_W-1:0] d_reg;
    logic signed [OW-1:0]    fv_reg;
    logic                    clip_reg;

    dph_pkg::uword_t         uw;
    logic                    accept_in, out_free, done_fire, cfg_wr;
    logic signed [EW-1:0]    cur_err, cur_prev;
    logic signed [EW:0]      diff;
    logic signed [IW-1:0]    int_src;
    logic signed [OPB_W-1:0] opb;
    logic [GW-1:0]           opa;
    logic signed [CW:0]      chunk;
    logic signed [MUL_W-1:0] mul_next;
    logic signed [FL_W-1:0]  acc_fl;
    logic signed [SUM_W-1:0] int_sum;
    logic signed [IW-1:0]    int_clamped;
    logic                    int_clip;
    logic signed [OW-1:0]    out_clamped;
    logic                    out_clip;
    logic signed [HW-1:0]    hr_in;
    logic signed [HW+1:0]    hw_t, hw_adj;

    // ------------------------------------------------------------------------
    // control word and handshakes
    // ------------------------------------------------------------------------
    assign uw        = dph_pkg::ucode(pc_reg);
    assign s_tready  = (uw.seq == dph_pkg::SEQ_WAIT_IN);
    assign accept_in = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign done_fire = (uw.seq == dph_pkg::SEQ_DONE) && out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    always_comb
    begin
        case (uw.seq)
            dph_pkg::SEQ_WAIT_IN: pc_next = accept_in ? pc_reg + PC_W'(1) : pc_reg;
            dph_pkg::SEQ_NEXT:    pc_next = pc_reg + PC_W'(1);
            dph_pkg::SEQ_DONE:    pc_next = out_free ? dph_pkg::PC_IDLE : pc_reg;
            default:              pc_next = dph_pkg::PC_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // heading wrap: one correction either way covers the 16-bit input range
    // ------------------------------------------------------------------------
    always_comb
    begin
        hr_in = signed'(s_tdata[EW + HW - 1:EW]);
        hw_t  = (HW + 2)'(hr_in) + dph_pkg::PI_Q12;
        if (hw_t < 0)
            hw_adj = hw_t + dph_pkg::TWO_PI_Q12;
        else if (hw_t >= dph_pkg::TWO_PI_Q12)
            hw_adj = hw_t - dph_pkg::TWO_PI_Q12;
        else
            hw_adj = hw_t;
    end

    // ------------------------------------------------------------------------
    // operand selection and multiplier
    // ------------------------------------------------------------------------
    assign cur_err  = (uw.ch == dph_pkg::CH_H) ? EW'(he_reg) : re_reg;
    assign cur_prev = (uw.ch == dph_pkg::CH_H) ? EW'(hp_reg) : rp_reg;
    assign diff     = (EW + 1)'(cur_err) - (EW + 1)'(cur_prev);

    always_comb
    begin
        case (uw.bsel)
            dph_pkg::B_ERR:  opb = OPB_W'(cur_err);
            dph_pkg::B_DIFF: opb = OPB_W'(diff);
            dph_pkg::B_INT:  opb = (uw.ch == dph_pkg::CH_H) ? OPB_W'(hi_reg) : OPB_W'(ri_reg);
            dph_pkg::B_DER:  opb = OPB_W'(d_reg);
            default:         opb = '0;
        endcase
    end

    always_comb
    begin
        case (uw.asel)
            dph_pkg::A_KP:   opa = (uw.ch == dph_pkg::CH_H) ? heading_kp_reg : range_kp_reg;
            dph_pkg::A_KI:   opa = (uw.ch == dph_pkg::CH_H) ? heading_ki_reg : range_ki_reg;
            dph_pkg::A_KD:   opa = (uw.ch == dph_pkg::CH_H) ? heading_kd_reg : range_kd_reg;
            dph_pkg::A_PER:  opa = GW'(period_reg);
            dph_pkg::A_RATE: opa = GW'(rate_reg);
            default:         opa = '0;
        endcase
    end

    // low chunk is unsigned, high chunk carries the sign
    assign chunk    = (uw.hi == dph_pkg::HI) ? (CW + 1)'(signed'(opb[OPB_W-1:CW]))
                                             : signed'({1'b0, opb[CW-1:0]});
    assign mul_next = signed'({1'b0, opa}) * chunk;

    // floor division by 4096
    assign acc_fl   = acc_reg[ACC_W-1:FW];

    // ------------------------------------------------------------------------
    // saturation
    // ------------------------------------------------------------------------
    assign int_src = (uw.wb == dph_pkg::WB_INT_H) ? hi_reg : ri_reg;
    assign int_sum = SUM_W'(int_src) + SUM_W'(acc_fl);

    always_comb
    begin
        int_clip = 1'b1;
        if (int_sum > I_MAX)
            int_clamped = I_MAX[IW-1:0];
        else if (int_sum < I_MIN)
            int_clamped = I_MIN[IW-1:0];
        else
        begin
            int_clamped = int_sum[IW-1:0];
            int_clip    = 1'b0;
        end
    end

    always_comb
    begin
        out_clip = 1'b1;
        if (sum_reg > O_MAX)
            out_clamped = O_MAX[OW-1:0];
        else if (sum_reg < O_MIN)
            out_clamped = O_MIN[OW-1:0];
        else
        begin
            out_clamped = sum_reg[OW-1:0];
            out_clip    = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // sequencer and output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= dph_pkg::PC_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (done_fire)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            m_tdata_reg <= {out_clamped, fv_reg};
            m_tuser_reg <= clip_reg | out_clip;
        end
    end

    // ------------------------------------------------------------------------
    // controller state: integrators and previous errors
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ri_reg <= '0;
            hi_reg <= '0;
            rp_reg <= '0;
            hp_reg <= '0;
        end
        else
        begin
            if (uw.wb == dph_pkg::WB_INT_R)
                ri_reg <= int_clamped;
            if (uw.wb == dph_pkg::WB_INT_H)
                hi_reg <= int_clamped;
            if (done_fire)
            begin
                rp_reg <= re_reg;
                hp_reg <= he_reg;
            end
        end
    end

    // ------------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            re_reg   <= signed'(s_tdata[EW-1:0]);
            he_reg   <= HW'(hw_adj - dph_pkg::PI_Q12);
            clip_reg <= 1'b0;
        end
        else if (uw.wb == dph_pkg::WB_INT_R || uw.wb == dph_pkg::WB_INT_H)
            clip_reg <= clip_reg | int_clip;
        else if (uw.wb == dph_pkg::WB_OUT_R)
            clip_reg <= clip_reg | out_clip;

        if (uw.mul_en)
            mul_reg <= mul_next;

        case (uw.acc)
            dph_pkg::ACC_LOAD:  acc_reg <= ACC_W'(mul_reg);
            dph_pkg::ACC_ADDHI: acc_reg <= acc_reg + {mul_reg[ACC_W-CW-1:0], CW'(0)};
            default:            acc_reg <= acc_reg;
        endcase

        case (uw.wb)
            dph_pkg::WB_DER:     d_reg   <= acc_reg[DER_W-1:0];
            dph_pkg::WB_SUM_LD:  sum_reg <= SUM_W'(acc_fl);
            dph_pkg::WB_SUM_ADD: sum_reg <= sum_reg + SUM_W'(acc_fl);
            dph_pkg::WB_OUT_R:   fv_reg  <= out_clamped;
            default:             ;
        endcase
    end

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_kp_reg   <= dph_pkg::RST_RANGE_KP;
            range_ki_reg   <= dph_pkg::RST_RANGE_KI;
            range_kd_reg   <= dph_pkg::RST_RANGE_KD;
            heading_kp_reg <= dph_pkg::RST_HEADING_KP;
            heading_ki_reg <= dph_pkg::RST_HEADING_KI;
            heading_kd_reg <= dph_pkg::RST_HEADING_KD;
            period_reg     <= dph_pkg::RST_PERIOD;
            rate_reg       <= dph_pkg::RST_RATE;
        end
        else if (cfg_wr)
        begin
            case (dph_pkg::reg_idx_t'(paddr[4:2]))
                dph_pkg::REG_RANGE_KP:   range_kp_reg   <= pwdata[GW-1:0];
                dph_pkg::REG_RANGE_KI:   range_ki_reg   <= pwdata[GW-1:0];
                dph_pkg::REG_RANGE_KD:   range_kd_reg   <= pwdata[GW-1:0];
                dph_pkg::REG_HEADING_KP: heading_kp_reg <= pwdata[GW-1:0];
                dph_pkg::REG_HEADING_KI: heading_ki_reg <= pwdata[GW-1:0];
                dph_pkg::REG_HEADING_KD: heading_kd_reg <= pwdata[GW-1:0];
                dph_pkg::REG_PERIOD:     period_reg     <= pwdata[dph_pkg::PERIOD_W-1:0];
                dph_pkg::REG_RATE:       rate_reg       <= pwdata[dph_pkg::RATE_W-1:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        case (dph_pkg::reg_idx_t'(paddr[4:2]))
            dph_pkg::REG_RANGE_KP:   prdata = dph_pkg::APB_DW'(range_kp_reg);
            dph_pkg::REG_RANGE_KI:   prdata = dph_pkg::APB_DW'(range_ki_reg);
            dph_pkg::REG_RANGE_KD:   prdata = dph_pkg::APB_DW'(range_kd_reg);
            dph_pkg::REG_HEADING_KP: prdata = dph_pkg::APB_DW'(heading_kp_reg);
            dph_pkg::REG_HEADING_KI: prdata = dph_pkg::APB_DW'(heading_ki_reg);
            dph_pkg::REG_HEADING_KD: prdata = dph_pkg::APB_DW'(heading_kd_reg);
            dph_pkg::REG_PERIOD:     prdata = dph_pkg::APB_DW'(period_reg);
            dph_pkg::REG_RATE:       prdata = dph_pkg::APB_DW'(rate_reg);
            default:                 prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- sim/dual_pid_range_heading_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_pid_range_heading_tb
// Self-checking bench for the two-channel PID block. A local predictor models
// heading wrap, saturating integrators, derivative and gain sums per item.
// Every result is compared with it, field by field. Register writes and
// read-back use the APB port. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
module dual_pid_range_heading_tb;

    localparam int HEAD_W   = dph_pkg::HEAD_W;
    localparam int OUT_W    = dph_pkg::OUT_W;
    localparam int GAIN_W   = dph_pkg::GAIN_W;
    localparam int PERIOD_W = dph_pkg::PERIOD_W;
    localparam int RATE_W   = dph_pkg::RATE_W;
    localparam int APB_AW   = dph_pkg::APB_AW;
    localparam int APB_DW   = dph_pkg::APB_DW;
    localparam int FRAC_W   = dph_pkg::FRAC_W;
    localparam longint PI_Q12     = dph_pkg::PI_Q12;
    localparam longint TWO_PI_Q12 = dph_pkg::TWO_PI_Q12;

    localparam int ERR_W = 24;
    localparam int INT_W = 32;
    localparam int S_W   = ((ERR_W + HEAD_W + 7) / 8) * 8;
    localparam int RPT_W = 2 * OUT_W;
    localparam logic [ERR_W-1:0] ERR_TOP    = {1'b0, {(ERR_W - 1){1'b1}}};
    localparam logic [ERR_W-1:0] ERR_BOTTOM = {1'b1, {(ERR_W - 1){1'b0}}};
    // Slowest legal run stays far below this limit (sequencer time per item plus
    // sender gaps, receiver stalls, the long hold and register traffic).
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [OUT_W-1:0] velocity;
        logic [OUT_W-1:0] turn;
        logic             clip;
    } pid_cmd_t;

    logic clk = 1'b0;
    logic rst_n;

    logic             s_tvalid;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata;      // [23:0] range_error, [39:24] heading_raw
    logic             m_tvalid;
    logic             m_tready;
    logic [2*OUT_W-1:0] m_tdata;    // [23:0] forward_velocity, [47:24] turn_rate
    logic [0:0]       m_tuser;      // [0] saturated
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic             pready;

    // Local copy of the register file, at register widths
    logic [GAIN_W-1:0]   gain_range_p = dph_pkg::RST_RANGE_KP;
    logic [GAIN_W-1:0]   gain_range_i = dph_pkg::RST_RANGE_KI;
    logic [GAIN_W-1:0]   gain_range_d = dph_pkg::RST_RANGE_KD;
    logic [GAIN_W-1:0]   gain_head_p  = dph_pkg::RST_HEADING_KP;
    logic [GAIN_W-1:0]   gain_head_i  = dph_pkg::RST_HEADING_KI;
    logic [GAIN_W-1:0]   gain_head_d  = dph_pkg::RST_HEADING_KD;
    logic [PERIOD_W-1:0] tick_dt      = dph_pkg::RST_PERIOD;
    logic [RATE_W-1:0]   tick_hz      = dph_pkg::RST_RATE;

    // Local copy of the controller state
    logic signed [INT_W-1:0]  range_acc  = '0;
    logic signed [INT_W-1:0]  head_acc   = '0;
    logic signed [ERR_W-1:0]  range_last = '0;
    logic signed [HEAD_W-1:0] head_last  = '0;

    pid_cmd_t pending_cmds[$];
    int       mismatches  = 0;
    int       burst_left  = 0;
    int       cycle_count = 0;
    // Long receiver hold-off: the test bumps hold_serial, the receiver counts
    int       hold_len    = 0;
    int       hold_serial = 0;
    logic [ERR_W-1:0]  walk_range = '0;
    logic [HEAD_W-1:0] walk_head  = '0;

    dual_pid_range_heading #(
        .ERROR_WIDTH      (ERR_W),
        .INTEGRATOR_WIDTH (INT_W)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Clamp to a signed w-bit range, flag any clip
    function automatic longint clip_signed(input longint x, input int w, inout bit clipped);
        longint hi_lim;
        longint lo_lim;
        hi_lim = (longint'(1) <<< (w - 1)) - 1;
        lo_lim = -hi_lim - 1;
        if (x > hi_lim)
        begin
            clipped = 1'b1;
            return hi_lim;
        end
        if (x < lo_lim)
        begin
            clipped = 1'b1;
            return lo_lim;
        end
        return x;
    endfunction

    // One PID channel; >>> on a signed longint is the floor of x / 4096
    function automatic longint pid_channel(input longint err, inout longint integ,
                                           inout longint prev, input longint kp,
                                           input longint ki, input longint kd,
                                           input longint dt, input longint hz,
                                           inout bit clipped);
        longint deriv;
        longint sum;
        integ = clip_signed(integ + ((err * dt) >>> FRAC_W), INT_W, clipped);
        deriv = (err - prev) * hz;      // full width, no clip
        prev  = err;
        sum   = ((kp * err) >>> FRAC_W) + ((ki * integ) >>> FRAC_W)
              + ((kd * deriv) >>> FRAC_W);
        return clip_signed(sum, OUT_W, clipped);
    endfunction

    // Expected command for one control tick; advances the local state
    function automatic pid_cmd_t predict_tick(input logic signed [ERR_W-1:0] range_err,
                                              input logic signed [HEAD_W-1:0] heading);
        longint   re;
        longint   wrapped;
        longint   r_int;
        longint   h_int;
        longint   r_prev;
        longint   h_prev;
        bit       clipped;
        pid_cmd_t cmd;
        re      = longint'(range_err);
        // floor modulo into [-pi, pi); % truncates toward zero, so fix up negatives
        wrapped = (longint'(heading) + PI_Q12) % TWO_PI_Q12;
        if (wrapped < 0)
            wrapped = wrapped + TWO_PI_Q12;
        wrapped = wrapped - PI_Q12;
        r_int   = longint'(range_acc);
        h_int   = longint'(head_acc);
        r_prev  = longint'(range_last);
        h_prev  = longint'(head_last);
        clipped = 1'b0;
        cmd.velocity = OUT_W'(pid_channel(re, r_int, r_prev, longint'(gain_range_p),
                                          longint'(gain_range_i), longint'(gain_range_d),
                                          longint'(tick_dt), longint'(tick_hz), clipped));
        cmd.turn     = OUT_W'(pid_channel(wrapped, h_int, h_prev, longint'(gain_head_p),
                                          longint'(gain_head_i), longint'(gain_head_d),
                                          longint'(tick_dt), longint'(tick_hz), clipped));
        cmd.clip     = clipped;
        range_acc  = r_int[INT_W-1:0];
        head_acc   = h_int[INT_W-1:0];
        range_last = r_prev[ERR_W-1:0];
        head_last  = h_prev[HEAD_W-1:0];
        return cmd;
    endfunction

    // ------------------------------------------------------------------
    // Random fields
    // ------------------------------------------------------------------

    // Mix of raw bits, small errors, extremes and a slowly drifting error
    function automatic logic [ERR_W-1:0] pick_range_error();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return ERR_W'($urandom());
        if (pick < 5)
            return ERR_W'($urandom_range(0, 32767) - 16384);
        if (pick == 5)
        begin
            case ($urandom_range(0, 4))
                0:       return ERR_TOP;
                1:       return ERR_BOTTOM;
                2:       return '1;
                3:       return '0;
                default: return ERR_W'(1);
            endcase
        end
        walk_range = ERR_W'(walk_range + $urandom_range(0, 4096) - 2048);
        return walk_range;
    endfunction

    // Unwrapped heading: raw bits, values around +-pi, or a drifting bearing
    // that crosses the wrap point now and then
    function automatic logic [HEAD_W-1:0] pick_heading();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return HEAD_W'($urandom());
        if (pick < 5)
            return HEAD_W'(($urandom_range(0, 1) ? 12868 : -12868)
                           + $urandom_range(0, 6) - 3);
        walk_head = HEAD_W'(walk_head + $urandom_range(0, 1600) - 800);
        return walk_head;
    endfunction

    // Register values in a range, at register width
    function automatic logic [GAIN_W-1:0] rand_gain(input int unsigned lo_val,
                                                    input int unsigned hi_val);
        return GAIN_W'($urandom_range(lo_val, hi_val));
    endfunction

    function automatic logic [PERIOD_W-1:0] rand_period(input int unsigned lo_val,
                                                        input int unsigned hi_val);
        return PERIOD_W'($urandom_range(lo_val, hi_val));
    endfunction

    function automatic logic [RATE_W-1:0] rand_rate(input int unsigned lo_val,
                                                    input int unsigned hi_val);
        return RATE_W'($urandom_range(lo_val, hi_val));
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting, shared by the result check and register read-back
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [RPT_W-1:0] want,
                                   input logic [RPT_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
    endtask

    // ------------------------------------------------------------------
    // Stream sender: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    task automatic send_tick(input logic [ERR_W-1:0] range_err,
                             input logic [HEAD_W-1:0] heading);
        int       gap;
        pid_cmd_t cmd;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {heading, range_err};
        do @(posedge clk); while (!s_tready);
        cmd = predict_tick(range_err, heading);
        pending_cmds.insert(pending_cmds.size(), cmd);
        burst_left--;
    endtask

    // Sender pauses until every expected command has come back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // APB access
    // ------------------------------------------------------------------
    function automatic logic [APB_DW-1:0] reg_value(input dph_pkg::reg_idx_t idx);
        case (idx)
            dph_pkg::REG_RANGE_KP:   return APB_DW'(gain_range_p);
            dph_pkg::REG_RANGE_KI:   return APB_DW'(gain_range_i);
            dph_pkg::REG_RANGE_KD:   return APB_DW'(gain_range_d);
            dph_pkg::REG_HEADING_KP: return APB_DW'(gain_head_p);
            dph_pkg::REG_HEADING_KI: return APB_DW'(gain_head_i);
            dph_pkg::REG_HEADING_KD: return APB_DW'(gain_head_d);
            dph_pkg::REG_PERIOD:     return APB_DW'(tick_dt);
            default:                 return APB_DW'(tick_hz);
        endcase
    endfunction

    // Bits above the register width carry junk; the block must drop them
    task automatic write_reg(input dph_pkg::reg_idx_t idx, input logic [GAIN_W-1:0] field);
        logic [APB_DW-1:0] data;
        data = $urandom();
        case (idx)
            dph_pkg::REG_PERIOD: data[PERIOD_W-1:0] = field[PERIOD_W-1:0];
            dph_pkg::REG_RATE:   data[RATE_W-1:0]   = field[RATE_W-1:0];
            default:             data[GAIN_W-1:0]   = field;
        endcase
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            dph_pkg::REG_RANGE_KP:   gain_range_p = data[GAIN_W-1:0];
            dph_pkg::REG_RANGE_KI:   gain_range_i = data[GAIN_W-1:0];
            dph_pkg::REG_RANGE_KD:   gain_range_d = data[GAIN_W-1:0];
            dph_pkg::REG_HEADING_KP: gain_head_p  = data[GAIN_W-1:0];
            dph_pkg::REG_HEADING_KI: gain_head_i  = data[GAIN_W-1:0];
            dph_pkg::REG_HEADING_KD: gain_head_d  = data[GAIN_W-1:0];
            dph_pkg::REG_PERIOD:     tick_dt      = data[PERIOD_W-1:0];
            default:                 tick_hz      = data[RATE_W-1:0];
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_check(input dph_pkg::reg_idx_t idx);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== reg_value(idx))
            report_mismatch(idx.name(), RPT_W'(reg_value(idx)), RPT_W'(prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_all_regs();
        dph_pkg::reg_idx_t idx;
        idx = idx.first();
        do
        begin
            read_check(idx);
            idx = idx.next();
        end
        while (idx != idx.first());
    endtask

    // Full register set, only once the block has gone idle
    task automatic load_config(input logic [GAIN_W-1:0] rkp, input logic [GAIN_W-1:0] rki,
                               input logic [GAIN_W-1:0] rkd, input logic [GAIN_W-1:0] hkp,
                               input logic [GAIN_W-1:0] hki, input logic [GAIN_W-1:0] hkd,
                               input logic [PERIOD_W-1:0] dt, input logic [RATE_W-1:0] hz);
        drain_results();
        write_reg(dph_pkg::REG_RANGE_KP, rkp);
        write_reg(dph_pkg::REG_RANGE_KI, rki);
        write_reg(dph_pkg::REG_RANGE_KD, rkd);
        write_reg(dph_pkg::REG_HEADING_KP, hkp);
        write_reg(dph_pkg::REG_HEADING_KI, hki);
        write_reg(dph_pkg::REG_HEADING_KD, hkd);
        write_reg(dph_pkg::REG_PERIOD, GAIN_W'(dt));
        write_reg(dph_pkg::REG_RATE, GAIN_W'(hz));
        read_all_regs();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_register_defaults();
        read_all_regs();
    endtask

    // Reset gains. First tick sees previous = 0, so the derivative kicks.
    // Then the field extremes and headings right at and across +-pi and 2pi.
    task automatic test_directed_ticks();
        int range_pts[13] = '{1000, 8388607, -8388608, 0, 0, 0, 0, 0, 0, 0, 0, -1, 0};
        int head_pts[13]  = '{3000, 0, 0, 32767, -32768, 12867, 12868, -12868, -12869,
                              25736, -25736, -1, 0};
        for (int k = 0; k < 13; k++)
            send_tick(ERR_W'(range_pts[k]), HEAD_W'(head_pts[k]));
    endtask

    // Period and rate of zero: integrator and derivative stay flat
    task automatic test_zero_period_rate();
        load_config(dph_pkg::RST_RANGE_KP, dph_pkg::RST_RANGE_KI, dph_pkg::RST_RANGE_KD,
                    dph_pkg::RST_HEADING_KP, dph_pkg::RST_HEADING_KI,
                    dph_pkg::RST_HEADING_KD, '0, '0);
        repeat (3) send_tick(pick_range_error(), pick_heading());
    endtask

    // All gains and timing at their top, then all gains at zero
    task automatic test_gain_extremes();
        load_config('1, '1, '1, '1, '1, '1, '1, '1);
        send_tick(ERR_TOP, 16'h7FFF);
        send_tick(ERR_BOTTOM, 16'h8000);
        send_tick(pick_range_error(), pick_heading());
        send_tick('1, 16'd1);
        load_config('0, '0, '0, '0, '0, '0, 12'd1, 10'd1);
        send_tick(ERR_TOP, 16'h8000);
        send_tick(pick_range_error(), pick_heading());
    endtask

    // Receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        load_config(rand_gain(0, 8192), rand_gain(0, 2048), rand_gain(0, 4096),
                    rand_gain(0, 8192), rand_gain(0, 2048), rand_gain(0, 4096),
                    rand_period(1, 4095), rand_rate(1, 1023));
        hold_len = 400;
        hold_serial++;
        repeat (12) send_tick(pick_range_error(), pick_heading());
        drain_results();
    endtask

    // Drive the range integrator into its top clip, then all the way down
    // into its bottom clip (about 256 and 512 ticks at full error).
    task automatic test_integrator_windup();
        load_config(rand_gain(0, 65535), rand_gain(0, 65535), rand_gain(0, 65535),
                    rand_gain(0, 65535), rand_gain(0, 65535), rand_gain(0, 65535),
                    '1, rand_rate(1, 1023));
        repeat (270) send_tick(ERR_W'(ERR_TOP - $urandom_range(0, 255)), pick_heading());
        load_config(rand_gain(0, 8192), '1, rand_gain(0, 4096),
                    rand_gain(0, 65535), rand_gain(0, 65535), rand_gain(0, 65535),
                    '1, rand_rate(0, 1023));
        repeat (525) send_tick(ERR_W'(ERR_BOTTOM + $urandom_range(0, 255)), pick_heading());
    endtask

    // Several register settings, random ticks under each
    task automatic test_random_phases();
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: load_config(rand_gain(0, 8192), rand_gain(0, 8192), rand_gain(0, 8192),
                               rand_gain(0, 8192), rand_gain(0, 8192), rand_gain(0, 8192),
                               rand_period(1, 4095), rand_rate(1, 1023));
                1: load_config(rand_gain(0, 65535), rand_gain(0, 65535),
                               rand_gain(0, 65535), rand_gain(0, 65535),
                               rand_gain(0, 65535), rand_gain(0, 65535), 12'd1, 10'd1);
                2: load_config(rand_gain(0, 65535), rand_gain(0, 65535),
                               rand_gain(0, 65535), rand_gain(0, 65535),
                               rand_gain(0, 65535), rand_gain(0, 65535),
                               rand_period(0, 4095), rand_rate(0, 1023));
                default: load_config(dph_pkg::RST_RANGE_KP, dph_pkg::RST_RANGE_KI,
                                     dph_pkg::RST_RANGE_KD, dph_pkg::RST_HEADING_KP,
                                     dph_pkg::RST_HEADING_KI, dph_pkg::RST_HEADING_KD,
                                     dph_pkg::RST_PERIOD, dph_pkg::RST_RATE);
            endcase
            repeat (55) send_tick(pick_range_error(), pick_heading());
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own, changing every so often, plus the
    // long hold-off requested through hold_serial
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int hold_left;
        int seen_serial;
        int pattern;
        int pattern_left;
        int tick;
        m_tready     = 1'b0;
        hold_left    = 0;
        seen_serial  = 0;
        pattern      = 0;
        pattern_left = 0;
        tick         = 0;
        forever
        begin
            @(negedge clk);
            if (hold_serial != seen_serial)
            begin
                seen_serial = hold_serial;
                hold_left   = hold_len;
            end
            if (pattern_left == 0)
            begin
                pattern      = $urandom_range(0, 3);
                pattern_left = $urandom_range(20, 300);
            end
            pattern_left--;
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (pattern)
                    0:       m_tready <= 1'b1;                          // no stalls
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= ((tick % 7) >= 3);             // periodic
                    default: m_tready <= ($urandom_range(0, 7) == 0);   // mostly stalled
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: every accepted item against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        pid_cmd_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_cmds.size() == 0)
                report_mismatch("unexpected result", '0, m_tdata);
            else
            begin
                want = pending_cmds.pop_front();
                if (m_tdata[OUT_W-1:0] !== want.velocity)
                    report_mismatch("forward_velocity", RPT_W'(want.velocity),
                                    RPT_W'(m_tdata[OUT_W-1:0]));
                if (m_tdata[2*OUT_W-1:OUT_W] !== want.turn)
                    report_mismatch("turn_rate", RPT_W'(want.turn),
                                    RPT_W'(m_tdata[2*OUT_W-1:OUT_W]));
                if (m_tuser[0] !== want.clip)
                    report_mismatch("saturated", RPT_W'(want.clip), RPT_W'(m_tuser[0]));
            end
        end
    end

    // Run-away guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_defaults();
        test_directed_ticks();
        test_zero_period_rate();
        test_gain_extremes();
        test_backpressure();
        test_integrator_windup();
        test_random_phases();

        drain_results();
        // settle time, so that any stray result still shows up
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending_cmds.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
